/* design/kta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kta_pkg
// Shared types and constants for the keyed table with aging.
// ----------------------------------------------------------------------------
package kta_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;
  localparam logic [1:0] CMD_AGE    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // Packed slot payload stored in RAM: key, dim, life, cx, cy, w, h, mode.
  localparam int SLOT_W = 16 + 8 + 31 + 16 + 16 + 16 + 16 + 1;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        key;
    logic [7:0]         dimension;
    logic [30:0]        lifespan;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic               shape_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_center_x;
    logic signed [15:0] out_center_y;
    logic [15:0]        out_width;
    logic [15:0]        out_height;
    logic               out_mode;
    logic [30:0]        remaining_life;
    logic [6:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  dimension;
    logic [30:0] life;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic        mode;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_WRITE,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input transaction
    logic clr_scan;  // reset scan index and match flags
    logic rd;        // issue RAM read at scan index
    logic eval;      // evaluate data of previous read
    logic commit;    // apply insert/erase outcome
    logic emit;      // build result
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_rd;   // read at final index issued
    logic done_early;// match found, scan can stop
  } sts_t;

endpackage

/* design/kta_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kta_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module kta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/kta_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kta_datapath
// Slot RAM, valid bits, scan index, match and free-slot search, aging.
// ----------------------------------------------------------------------------
module kta_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kta_pkg::ctl_t     ctl,
  input  kta_pkg::in_item_t in_item,
  output kta_pkg::sts_t     sts,
  output kta_pkg::out_item_t res
);
  import kta_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  in_item_t        req_r;
  logic [AW-1:0]   rd_idx_r;   // address being read
  logic [AW-1:0]   ev_idx_r;   // address whose data is on rdata
  logic            ev_valid_r; // valid bit of the address on rdata
  logic            last_issued_r;
  logic            hit_r, free_found_r;
  logic [AW-1:0]   hit_idx_r, free_idx_r;
  slot_t           hit_slot_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]   count_r;
  out_item_t       res_r;
  out_item_t       res_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  slot_t           wdata, rdata;
  logic [SLOT_W-1:0] rdata_raw;
  logic            at_last;
  logic            ins_ok, ers_ok;
  logic [CW-1:0]   count_after;

  kta_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rd_idx_r), .rdata(rdata_raw)
  );
  assign rdata = slot_t'(rdata_raw);

  logic ev_valid, ev_match, ev_expire;
  assign ev_valid  = ev_valid_r;
  assign ev_match  = ev_valid && rdata.key == req_r.key && rdata.dimension == req_r.dimension;
  assign ev_expire = rdata.life <= {15'd0, req_r.elapsed_ms};

  assign at_last = rd_idx_r == AW'(CAPACITY - 1);
  assign ins_ok  = req_r.command == CMD_INSERT && !hit_r && free_found_r;
  assign ers_ok  = req_r.command == CMD_ERASE && hit_r;

  // Count as it stands once the commit of this transaction lands.
  always_comb begin
    if (ins_ok)      count_after = count_r + 1'b1;
    else if (ers_ok) count_after = count_r - 1'b1;
    else             count_after = count_r;
  end

  // Write port: age writeback during eval, insert on commit.
  always_comb begin
    we    = 1'b0;
    waddr = ev_idx_r;
    wdata = rdata;
    if (ctl.eval && req_r.command == CMD_AGE && ev_valid && !ev_expire) begin
      we = 1'b1;
      wdata.life = rdata.life - {15'd0, req_r.elapsed_ms};
    end else if (ctl.commit && ins_ok) begin
      we    = 1'b1;
      waddr = free_idx_r;
      wdata = '{key: req_r.key, dimension: req_r.dimension, life: req_r.lifespan,
                cx: req_r.center_x, cy: req_r.center_y, w: req_r.box_width,
                h: req_r.box_height, mode: req_r.shape_mode};
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.entry_count = 7'(count_after);
    unique case (req_r.command)
      CMD_INSERT: res_nxt.status = hit_r ? ST_DUP : (free_found_r ? ST_OK : ST_FULL);
      CMD_FIND: begin
        if (hit_r) begin
          res_nxt.status         = ST_OK;
          res_nxt.out_center_x   = hit_slot_r.cx;
          res_nxt.out_center_y   = hit_slot_r.cy;
          res_nxt.out_width      = hit_slot_r.w;
          res_nxt.out_height     = hit_slot_r.h;
          res_nxt.out_mode       = hit_slot_r.mode;
          res_nxt.remaining_life = hit_slot_r.life;
        end else begin
          res_nxt.status = ST_MISS;
        end
      end
      CMD_ERASE: res_nxt.status = hit_r ? ST_OK : ST_MISS;
      CMD_AGE:   res_nxt.status = ST_OK;
    endcase
  end

  assign sts.last_rd    = last_issued_r;
  assign sts.done_early = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      hit_r <= 1'b0;
      free_found_r <= 1'b0;
      rd_idx_r <= '0;
      last_issued_r <= 1'b0;
    end else begin
      if (ctl.load) req_r <= in_item;
      if (ctl.clr_scan) begin
        rd_idx_r      <= '0;
        last_issued_r <= 1'b0;
        hit_r         <= 1'b0;
        free_found_r  <= 1'b0;
      end else if (ctl.rd) begin
        // hold the index on the final slot and flag it
        if (at_last) last_issued_r <= 1'b1;
        else         rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (ctl.rd) begin
        ev_idx_r   <= rd_idx_r;
        ev_valid_r <= valid_r[rd_idx_r];
      end
      if (ctl.eval) begin
        if (req_r.command == CMD_AGE) begin
          if (ev_valid && ev_expire) begin
            valid_r[ev_idx_r] <= 1'b0;
            count_r <= count_r - 1'b1;
          end
        end else begin
          if (ev_match && !hit_r) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= ev_idx_r;
            hit_slot_r <= rdata;
          end
          if (!ev_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= ev_idx_r;
          end
        end
      end
      if (ctl.commit) begin
        if (ins_ok) begin
          valid_r[free_idx_r] <= 1'b1;
          count_r <= count_r + 1'b1;
        end else if (ers_ok) begin
          valid_r[hit_idx_r] <= 1'b0;
          count_r <= count_r - 1'b1;
        end
      end
      if (ctl.emit) res_r <= res_nxt;
    end
  end

  assign res = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count above capacity");
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> count_r == CW'($countones(valid_r))) else $error("count mismatch");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !ctl.eval) else $error("eval and commit overlap");
endmodule

/* design/kta_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kta_ctrl
// Command sequencer: accept, scan slots, commit, present result.
// ----------------------------------------------------------------------------
module kta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic [1:0]    command,
  input  kta_pkg::sts_t sts,
  output kta_pkg::ctl_t ctl
);
  import kta_pkg::*;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_EVAL;
      S_EVAL: begin
        // stop early on a match for find and erase
        if (sts.done_early && command != CMD_AGE && command != CMD_INSERT)
          state_nxt = S_WRITE;
        else if (sts.last_rd) state_nxt = S_WRITE;
      end
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs. Reads are pipelined: read index i while evaluating index i-1.
  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        ctl.load     = in_valid;
        ctl.clr_scan = 1'b1;
      end
      S_SCAN: ctl.rd = 1'b1;
      S_EVAL: begin
        ctl.eval = 1'b1;
        ctl.rd   = !sts.last_rd;
      end
      S_WRITE: begin
        ctl.commit = 1'b1;
        ctl.emit   = 1'b1;
      end
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

/* design/keyed_table_with_aging.sv */
`timescale 1ns / 1ps
// Scan: an accepted transaction reads the CAPACITY slots, one slot per cycle
//   through the RAM read port; find and erase that hit a slot stop the scan
//   after the hit and present the result early.
// Throughput: one transaction at a time; the next accept can come in the cycle
//   after the result handoff.
// Reset: synchronous active-low rst_n clears valid bits, count and controller;
//   slot RAM contents need no clearing.
// ----------------------------------------------------------------------------
// keyed_table_with_aging
// Associative table of keyed box entries with lifetime aging.
// ----------------------------------------------------------------------------
module keyed_table_with_aging #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kta_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kta_pkg::out_item_t out_data
);
  import kta_pkg::*;

  ctl_t       ctl;
  sts_t       sts;
  logic [1:0] req_cmd_r;

  always_ff @(posedge clk) begin
    if (ctl.load) req_cmd_r <= in_data.command;
  end

  kta_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .command(req_cmd_r),
    .sts(sts), .ctl(ctl)
  );

  kta_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_item(in_data), .sts(sts), .res(out_data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_emit_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid) else $error("result not presented after emit");
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("accept while busy");
endmodule
